### src/scec_pkg.sv
// Shared types and constants of the serial CRC encode and check unit.
package scec_pkg;

    localparam int unsigned POLY_W      = 32;
    localparam int unsigned DEGREE_W    = 6;
    localparam int unsigned REM_W       = 32;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [POLY_W-1:0]   POLY_LOW_RESET = 32'd7;
    localparam logic [DEGREE_W-1:0] DEGREE_RESET   = 6'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POLY_LOW = 4'd0,
        REG_DEGREE   = 4'd1
    } cfg_index_t;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_CHECK  = 1'b1
    } op_t;

    typedef struct packed {
        logic op;
        logic data_bit;
        logic last;
    } in_word_t;

    typedef struct packed {
        logic [REM_W-1:0] remainder;
        logic             error_flag;
    } out_word_t;

    typedef struct packed {
        logic [POLY_W-1:0]   poly_low;
        logic [DEGREE_W-1:0] degree;
    } cfg_t;

endpackage

### src/scec_crc_step.sv
// One bit step of the configurable CRC shift register.
module scec_crc_step #(
    parameter int unsigned MAX_DEGREE = 32
) (
    input  scec_pkg::cfg_t          cfg,
    input  logic                    op,
    input  logic                    data_bit,
    input  logic [MAX_DEGREE-1:0]   rem_cur,
    output logic [MAX_DEGREE-1:0]   rem_step
);
    import scec_pkg::*;

    localparam int unsigned EFF_W = $clog2(MAX_DEGREE + 1) + 1;
    localparam int unsigned CMP_W = (EFF_W > DEGREE_W) ? EFF_W : DEGREE_W;

    logic [CMP_W-1:0]      deg_wide;
    logic [CMP_W-1:0]      deg_eff;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] top_sel;
    logic [MAX_DEGREE-1:0] gen;
    logic [MAX_DEGREE-1:0] rem_masked;
    logic [MAX_DEGREE-1:0] shifted;
    logic                  top;
    logic                  feedback;

    assign deg_wide = CMP_W'(cfg.degree);

    always_comb begin
        if (deg_wide == '0) begin
            deg_eff = CMP_W'(1);
        end else if (deg_wide > CMP_W'(MAX_DEGREE)) begin
            deg_eff = CMP_W'(MAX_DEGREE);
        end else begin
            deg_eff = deg_wide;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_DEGREE; i++) begin
            mask[i]    = (CMP_W'(i) < deg_eff);
            top_sel[i] = (CMP_W'(i + 1) == deg_eff);
        end
    end

    assign gen        = MAX_DEGREE'({{MAX_DEGREE{1'b0}}, cfg.poly_low}) & mask;
    assign rem_masked = rem_cur & mask;
    assign top        = |(rem_masked & top_sel);

    always_comb begin
        if (op == OP_ENCODE) begin
            feedback = top ^ data_bit;
            shifted  = (rem_masked << 1) & mask;
        end else begin
            feedback = top;
            shifted  = ((rem_masked << 1) | MAX_DEGREE'(data_bit)) & mask;
        end
        rem_step = feedback ? (shifted ^ gen) : shifted;
    end

endmodule

### src/serial_crc_encode_check_unit.sv
// Top level of the bit-serial CRC encoder and checker.
// One message bit is taken per word and cycle, most significant bit first; each
// bit updates the running remainder in the same cycle through one shift and
// XOR stage, so the unit sustains one word per cycle. A word marked last
// yields one registered result word with the remainder right-justified,
// and the running remainder starts again from zero. Results sit in a two-entry
// output buffer, so input words keep flowing while a result waits; input
// stalls only when both entries hold unread results.
module serial_crc_encode_check_unit #(
    parameter int unsigned MAX_DEGREE = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  scec_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output scec_pkg::out_word_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scec_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import scec_pkg::*;

    cfg_t                  cfg_reg;
    logic [MAX_DEGREE-1:0] rem_reg;
    logic [MAX_DEGREE-1:0] rem_next;
    logic [MAX_DEGREE-1:0] rem_step;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    out_word_t             out_reg;
    out_word_t             skid_reg;
    out_word_t             result;
    logic                  accept;
    logic                  push;
    logic                  pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign accept    = s_valid && s_ready;
    assign push      = accept && s_data.last;
    assign pop       = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poly_low <= POLY_LOW_RESET;
            cfg_reg.degree   <= DEGREE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_POLY_LOW: cfg_reg.poly_low <= cfg_data;
                REG_DEGREE:   cfg_reg.degree   <= cfg_data[DEGREE_W-1:0];
                default: ;
            endcase
        end
    end

    scec_crc_step #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_step (
        .cfg      (cfg_reg),
        .op       (s_data.op),
        .data_bit (s_data.data_bit),
        .rem_cur  (rem_reg),
        .rem_step (rem_step)
    );

    assign result.remainder  = REM_W'({{REM_W{1'b0}}, rem_step});
    assign result.error_flag = |rem_step;

    always_comb begin
        rem_next = rem_reg;
        if (accept) begin
            rem_next = s_data.last ? '0 : rem_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg) begin
            out_valid_reg <= push;
            if (push) begin
                out_reg <= result;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= push;
                if (push) begin
                    skid_reg <= result;
                end
            end else begin
                out_valid_reg <= push;
                if (push) begin
                    out_reg <= result;
                end
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
            skid_reg       <= result;
        end
    end

endmodule

### src/scec_checker.sv
// Port-level assertions for the serial CRC encode and check unit, with bind.
module scec_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  scec_pkg::in_word_t                  s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  scec_pkg::out_word_t                 m_data
);
    import scec_pkg::*;

    // A stalled result word holds its place and value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A zero error flag always comes with a zero remainder.
    a_flag_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.error_flag |-> m_data.remainder == '0)
        else $error("error flag clear with nonzero remainder");

    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> m_valid)
        else $error("word marked last gave no result");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !(s_valid && s_ready && s_data.last) |=> !m_valid)
        else $error("result appeared without a word marked last");

endmodule

bind serial_crc_encode_check_unit scec_checker u_scec_checker (.*);

### tb/crc_result_checker.sv
// Checker for the serial CRC unit: tracks configuration, predicts remainders and compares results.
module crc_result_checker #(
    parameter int unsigned MAX_DEGREE = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  scec_pkg::in_word_t                  s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  scec_pkg::out_word_t                 m_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [scec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scec_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int unsigned                         fail_count,
    output int unsigned                         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import scec_pkg::*;

    logic [POLY_W-1:0]   poly_setting;
    logic [DEGREE_W-1:0] degree_setting;
    logic [63:0]         running_rem;
    out_word_t           expected_results[$];
    int unsigned         mismatches;

    initial begin
        fail_count = 0;
        pending    = 0;
        mismatches = 0;
    end

    function automatic logic [63:0] shift_in_bit(input logic [63:0] rem,
                                                 input logic [POLY_W-1:0] poly,
                                                 input logic [DEGREE_W-1:0] deg,
                                                 input in_word_t w);
        int unsigned d;
        logic [63:0] mask;
        logic [63:0] gen;
        logic [63:0] r;
        logic        fb;
        d = 32'(deg);
        if (d < 1) d = 1;
        if (d > MAX_DEGREE) d = MAX_DEGREE;
        if (d > 64) d = 64;
        mask = (d >= 64) ? '1 : ((64'd1 << d) - 64'd1);
        gen  = {32'd0, poly} & mask;
        r    = rem & mask;
        fb   = r[d-1];
        if (w.op == OP_ENCODE) begin
            fb = fb ^ w.data_bit;
            r  = (r << 1) & mask;
        end else begin
            r  = ((r << 1) | {63'd0, w.data_bit}) & mask;
        end
        if (fb) r = r ^ gen;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_word_t   want;
        logic [63:0] next_rem;
        if (!aresetn) begin
            poly_setting   = POLY_LOW_RESET;
            degree_setting = DEGREE_RESET;
            running_rem    = '0;
            expected_results.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word remainder=%h error_flag=%b",
                                 $realtime, m_data.remainder, m_data.error_flag);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.remainder !== want.remainder ||
                        m_data.error_flag !== want.error_flag) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result mismatch: expected remainder=%h ",
                                      "error_flag=%b, got remainder=%h error_flag=%b"},
                                     $realtime, want.remainder, want.error_flag,
                                     m_data.remainder, m_data.error_flag);
                    end
                end
            end
            if (s_valid && s_ready) begin
                next_rem = shift_in_bit(running_rem, poly_setting, degree_setting, s_data);
                if (s_data.last) begin
                    want.remainder  = next_rem[REM_W-1:0];
                    want.error_flag = (next_rem != 64'd0);
                    expected_results.insert(expected_results.size(), want);
                    running_rem = '0;
                end else begin
                    running_rem = next_rem;
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_POLY_LOW)
                    poly_setting = cfg_data[POLY_W-1:0];
                else if (cfg_index == REG_DEGREE)
                    degree_setting = cfg_data[DEGREE_W-1:0];
            end
            pending <= expected_results.size();
        end
        fail_count <= mismatches;
    end

endmodule

### tb/tb_serial_crc_encode_check_unit.sv
// Testbench top for the serial CRC unit: clock, reset, stimulus and the final verdict.
module tb_serial_crc_encode_check_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import scec_pkg::*;

    localparam int unsigned MAX_DEG       = 32;
    localparam int unsigned TOTAL_BITS    = 1250;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 4'hF;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_word_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_word_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int unsigned            fail_count;
    int unsigned            pending;

    bit                     gaps_on   = 1'b1;
    bit                     stalls_on = 1'b1;
    int unsigned            bits_sent = 0;
    logic [POLY_W-1:0]      poly_now  = POLY_LOW_RESET;
    logic [DEGREE_W-1:0]    degree_now = DEGREE_RESET;

    always #5 aclk = ~aclk;

    serial_crc_encode_check_unit #(.MAX_DEGREE(MAX_DEG)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    crc_result_checker #(.MAX_DEGREE(MAX_DEG)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever begin
            @(posedge aclk);
            if (stalls_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_bit(input op_t op, input logic b, input logic last);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_data  <= '{op: op, data_bit: b, last: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        bits_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [POLY_W-1:0] poly,
                                 input logic [CFG_DATA_W-1:0] degree_word,
                                 input bit touch_spare);
        write_reg(REG_POLY_LOW, poly);
        write_reg(REG_DEGREE, degree_word);
        if (touch_spare)
            write_reg(REG_SPARE, $urandom);
        cfg_valid  <= 1'b0;
        poly_now   = poly;
        degree_now = degree_word[DEGREE_W-1:0];
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (pending != 0 && waited < 20000);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Fill: 0 random, 1 all zeros, 2 all ones.
    task automatic send_message(input op_t op, input int unsigned len, input bit mixed_op,
                                input int unsigned fill, input bit close);
        op_t  bit_op;
        logic b;
        for (int unsigned i = 0; i < len; i++) begin
            bit_op = mixed_op ? op_t'($urandom_range(0, 1)) : op;
            b = (fill == 0) ? logic'($urandom_range(0, 1)) : (fill == 2);
            send_bit(bit_op, b, close && (i == len - 1));
        end
    endtask

    // A multiple of the generator leaves a zero remainder in check mode.
    task automatic send_codeword(input int unsigned qlen);
        int unsigned d;
        logic [63:0] gen;
        logic [63:0] word;
        logic [31:0] quotient;
        d = 32'(degree_now);
        if (d < 1) d = 1;
        if (d > MAX_DEG) d = MAX_DEG;
        gen = (64'd1 << d) | ({32'd0, poly_now} & ((64'd1 << d) - 64'd1));
        quotient = $urandom;
        quotient[qlen-1] = 1'b1;
        word = '0;
        for (int unsigned i = 0; i < qlen; i++)
            if (quotient[i]) word = word ^ (gen << i);
        for (int unsigned i = qlen + d; i > 0; i--)
            send_bit(OP_CHECK, word[i-1], i == 1);
    endtask

    initial begin
        logic [7:0]            pattern;
        logic [POLY_W-1:0]     poly;
        logic [CFG_DATA_W-1:0] degree_word;
        int unsigned           messages;
        int unsigned           kind;
        int unsigned           len;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_bit(OP_ENCODE, 1'b1, 1'b1);
        send_bit(OP_CHECK, 1'b1, 1'b0);
        send_bit(OP_CHECK, 1'b0, 1'b0);
        send_bit(OP_CHECK, 1'b1, 1'b1);
        pattern = 8'hA5;
        for (int i = 7; i >= 0; i--)
            send_bit(OP_ENCODE, pattern[i], i == 0);
        send_bit(OP_ENCODE, 1'b1, 1'b0);
        send_bit(OP_CHECK, 1'b1, 1'b0);
        send_bit(OP_ENCODE, 1'b0, 1'b0);
        send_bit(OP_CHECK, 1'b1, 1'b1);
        settle();

        apply_setting(32'hFFFF_FFFF, 32'd0, 1'b1);
        send_bit(OP_CHECK, 1'b1, 1'b0);
        send_bit(OP_CHECK, 1'b1, 1'b1);
        settle();

        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_message(OP_ENCODE, 3, 1'b0, 2, 1'b1);
        settle();

        apply_setting(32'h0, 32'd32, 1'b0);
        send_bit(OP_CHECK, 1'b1, 1'b1);
        send_bit(OP_ENCODE, 1'b1, 1'b0);
        send_bit(OP_ENCODE, 1'b0, 1'b0);
        send_bit(OP_ENCODE, 1'b1, 1'b0);
        settle();

        apply_setting(32'h04C1_1DB7, 32'd1, 1'b0);
        send_bit(OP_ENCODE, 1'b1, 1'b1);
        settle();

        while (bits_sent < TOTAL_BITS) begin
            if (bits_sent + 200 > TOTAL_BITS) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 7))
                0:       poly = '0;
                1:       poly = '1;
                default: poly = $urandom;
            endcase
            degree_word = $urandom;
            case ($urandom_range(0, 9))
                0:       degree_word[DEGREE_W-1:0] = 6'd0;
                1:       degree_word[DEGREE_W-1:0] = 6'd1;
                2:       degree_word[DEGREE_W-1:0] = 6'd32;
                3:       degree_word[DEGREE_W-1:0] = DEGREE_W'($urandom_range(33, 63));
                4:       degree_word[DEGREE_W-1:0] = 6'd8;
                default: degree_word[DEGREE_W-1:0] = DEGREE_W'($urandom_range(1, 32));
            endcase
            apply_setting(poly, degree_word, $urandom_range(0, 7) == 0);

            messages = $urandom_range(2, 10);
            for (int unsigned m = 0; m < messages && bits_sent < TOTAL_BITS; m++) begin
                kind = $urandom_range(0, 9);
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 80)
                                                   : $urandom_range(1, 24);
                if (kind <= 2)
                    send_codeword($urandom_range(1, 31));
                else if (kind == 3)
                    send_message(OP_ENCODE, len, 1'b1, 0, 1'b1);
                else if (kind == 4)
                    send_message(op_t'($urandom_range(0, 1)), len, 1'b0, 1, 1'b1);
                else if (kind == 5)
                    send_message(op_t'($urandom_range(0, 1)), len, 1'b0, 2, 1'b1);
                else
                    send_message(op_t'($urandom_range(0, 1)), len, 1'b0, 0,
                                 (m + 1 < messages) || ($urandom_range(0, 4) != 0));
            end
            settle();
        end

        send_bit(OP_CHECK, 1'b0, 1'b1);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
